// ===== hw/rtl/slt_pkg.sv =====
// Shared types and constants of the stream slot table.
package slt_pkg;

  localparam int unsigned MaxSlotsDef = 16;
  localparam int unsigned EntryW      = 128;
  localparam int unsigned LimW        = 7;

  localparam logic [4:0]  MaxStreamsRst = 5'd16;
  localparam logic [30:0] TimeoutRst    = 31'd10000;

  localparam logic CfgMaxStreams = 1'b0;
  localparam logic CfgTimeout    = 1'b1;

  localparam logic [1:0] StRegistering = 2'd0;
  localparam logic [1:0] StActive      = 2'd1;
  localparam logic [1:0] StInactive    = 2'd2;
  localparam logic [1:0] StError       = 2'd3;

  typedef enum logic [3:0] {
    KIND_REGISTER   = 4'd0,
    KIND_UNREGISTER = 4'd1,
    KIND_ACTIVATE   = 4'd2,
    KIND_DEACTIVATE = 4'd3,
    KIND_SWITCH     = 4'd4,
    KIND_UPDATE     = 4'd5,
    KIND_CHECK      = 4'd6,
    KIND_QUERY      = 4'd7,
    KIND_CLEAR      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_TEST,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic rd_scan;
    logic exec;
    logic scan_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic is_check;
    logic out_free;
    logic need_push;
    logic scan_last;
  } stat_t;

  typedef struct packed {
    logic [4:0]  stream_count;
    logic [3:0]  current_slot;
    logic        current_valid;
    logic [47:0] byte_total;
    logic [31:0] frame_total;
    logic [1:0]  slot_status;
    logic        slot_present;
    logic [3:0]  slot_out;
    logic        ok;
  } res_t;

endpackage

// ===== hw/rtl/slt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module slt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/slt_ctrl.sv =====
// Controller state machine of the stream slot table.
module slt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  slt_pkg::stat_t stat_i,
  output slt_pkg::cmd_t  cmd_o
);

  slt_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      slt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.is_check) begin
            state_d = slt_pkg::S_SCAN_RD;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = slt_pkg::S_EXEC;
          end
        end
      end
      slt_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = slt_pkg::S_IDLE;
        end
      end
      slt_pkg::S_SCAN_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_scan = 1'b1;
        state_d       = slt_pkg::S_SCAN_TEST;
      end
      slt_pkg::S_SCAN_TEST: begin
        if (!(stat_i.need_push && !stat_i.out_free)) begin
          cmd_o.scan_step = 1'b1;
          state_d = stat_i.scan_last ? slt_pkg::S_FIN : slt_pkg::S_SCAN_RD;
        end
      end
      slt_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = slt_pkg::S_IDLE;
        end
      end
      default: state_d = slt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/slt_dp.sv =====
// Datapath of the stream slot table: slot flags, entry RAM, result registers.
module slt_dp #(
  parameter int unsigned MaxSlots = slt_pkg::MaxSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [79:0]    in_data_i,
  input  logic [3:0]     in_kind_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [30:0]    cfg_data_i,
  input  slt_pkg::cmd_t  cmd_i,
  output slt_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slt_pkg::res_t  out_res_o,
  output logic           out_last_o
);

  localparam int unsigned SW = MaxSlots > 1 ? $clog2(MaxSlots) : 1;
  localparam int unsigned CW = $clog2(MaxSlots + 1);
  localparam int unsigned LW = slt_pkg::LimW;

  logic [4:0]                max_q;
  logic [30:0]               tmo_q;
  logic [MaxSlots-1:0]       pres_q, pres_d;
  logic [MaxSlots-1:0][1:0]  st_q, st_d;
  logic                      sel_v_q, sel_v_d;
  logic [SW-1:0]             sel_q, sel_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [3:0]                kind_q;
  logic [3:0]                slot_q;
  logic [23:0]               dsz_q;
  logic [47:0]               now_q;
  logic [SW-1:0]             idx_q, idx_d;
  logic                      pend_v_q, pend_v_d;
  slt_pkg::res_t             pend_q, pend_d;
  logic                      out_v_q;
  slt_pkg::res_t             out_q;
  logic                      out_last_q;

  logic                      push;
  slt_pkg::res_t             push_res;
  logic                      push_last;

  logic                      ram_we;
  logic [SW-1:0]             ram_waddr, ram_raddr;
  logic [slt_pkg::EntryW-1:0] ram_wdata, ram_rdata;
  logic [47:0]               r_last, r_byte;
  logic [31:0]               r_frame;

  logic [LW-1:0]             lim;
  logic                      s_in, s_pres, s_valid;
  logic [SW-1:0]             sidx;
  logic [31:0]               frame_inc;
  logic [48:0]               bsum;
  logic [47:0]               byte_new;
  logic                      got;
  logic [SW-1:0]             gidx;
  logic                      hit;
  logic [47:0]               age;
  slt_pkg::res_t             res, hit_res;
  logic                      d_on, d_ok;
  logic [SW-1:0]             d_slot;
  logic [31:0]               d_frame;
  logic [47:0]               d_byte;

  assign {r_last, r_frame, r_byte} = ram_rdata;
  assign ram_raddr = cmd_i.rd_scan ? idx_q : SW'(in_data_i[3:0]);

  slt_ram #(
    .Width(slt_pkg::EntryW),
    .Depth(MaxSlots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    lim = ({2'b0, max_q} > LW'(MaxSlots)) ? LW'(MaxSlots) : {2'b0, max_q};
    s_in    = {3'b0, slot_q} < LW'(MaxSlots);
    sidx    = SW'(slot_q);
    s_pres  = s_in && pres_q[sidx];
    s_valid = s_pres && ({3'b0, slot_q} < lim);
    frame_inc = (&r_frame) ? r_frame : r_frame + 32'd1;
    bsum      = {1'b0, r_byte} + {25'b0, dsz_q};
    byte_new  = bsum[48] ? '1 : bsum[47:0];
    got  = 1'b0;
    gidx = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      if (!got && !pres_q[i] && (LW'(i) < lim)) begin
        got  = 1'b1;
        gidx = SW'(i);
      end
    end
    got = got && (LW'(cnt_q) < lim);
    age = now_q - r_last;
    hit = pres_q[idx_q] && (st_q[idx_q] == slt_pkg::StActive) &&
          (now_q > r_last) && (age > {17'b0, tmo_q});
  end

  always_comb begin
    pres_d    = pres_q;
    st_d      = st_q;
    sel_v_d   = sel_v_q;
    sel_d     = sel_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    ram_we    = 1'b0;
    ram_waddr = sidx;
    ram_wdata = {now_q, r_frame, r_byte};
    push      = 1'b0;
    push_res  = '0;
    push_last = 1'b1;
    d_on      = s_in;
    d_ok      = 1'b0;
    d_slot    = sidx;
    d_frame   = r_frame;
    d_byte    = r_byte;
    res       = '0;
    hit_res   = '0;

    if (cmd_i.accept) begin
      idx_d    = '0;
      pend_v_d = 1'b0;
    end

    if (cmd_i.exec) begin
      case (slt_pkg::kind_e'(kind_q))
        slt_pkg::KIND_REGISTER: begin
          d_on    = got;
          d_ok    = got;
          d_slot  = gidx;
          d_frame = '0;
          d_byte  = '0;
          if (got) begin
            pres_d[gidx] = 1'b1;
            st_d[gidx]   = slt_pkg::StRegistering;
            ram_we       = 1'b1;
            ram_waddr    = gidx;
            ram_wdata    = {now_q, 32'b0, 48'b0};
            cnt_d        = cnt_q + CW'(1);
          end
        end
        slt_pkg::KIND_UNREGISTER: begin
          d_ok = s_valid;
          if (s_valid) begin
            if (sel_v_q && sel_q == sidx) begin
              sel_v_d = 1'b0;
              sel_d   = '0;
            end
            pres_d[sidx] = 1'b0;
            st_d[sidx]   = slt_pkg::StRegistering;
            cnt_d        = cnt_q - CW'(1);
          end
        end
        slt_pkg::KIND_ACTIVATE: begin
          d_ok = s_valid;
          if (s_valid) begin
            st_d[sidx] = slt_pkg::StActive;
            ram_we     = 1'b1;
          end
        end
        slt_pkg::KIND_DEACTIVATE: begin
          d_ok = s_valid;
          if (s_valid) begin
            st_d[sidx] = slt_pkg::StInactive;
            if (sel_v_q && sel_q == sidx) begin
              sel_v_d = 1'b0;
              sel_d   = '0;
            end
          end
        end
        slt_pkg::KIND_SWITCH: begin
          d_ok = s_valid && (st_q[sidx] == slt_pkg::StActive);
          if (d_ok) begin
            sel_v_d = 1'b1;
            sel_d   = sidx;
          end
        end
        slt_pkg::KIND_UPDATE: begin
          d_ok = s_pres;
          if (s_pres) begin
            d_frame   = frame_inc;
            d_byte    = byte_new;
            ram_we    = 1'b1;
            ram_wdata = {now_q, frame_inc, byte_new};
          end
        end
        slt_pkg::KIND_QUERY: begin
          d_ok = s_pres;
        end
        slt_pkg::KIND_CLEAR: begin
          d_on    = 1'b0;
          d_ok    = 1'b1;
          pres_d  = '0;
          st_d    = '0;
          sel_v_d = 1'b0;
          sel_d   = '0;
          cnt_d   = '0;
        end
        default: begin
          d_on = 1'b0;
        end
      endcase
      res.ok = d_ok;
      if (d_on) begin
        res.slot_out = 4'(d_slot);
        if (pres_d[d_slot]) begin
          res.slot_present = 1'b1;
          res.slot_status  = st_d[d_slot];
          res.frame_total  = d_frame;
          res.byte_total   = d_byte;
        end
      end
      res.current_valid = sel_v_d;
      res.current_slot  = sel_v_d ? 4'(sel_d) : 4'b0;
      res.stream_count  = 5'(cnt_d);
      push     = 1'b1;
      push_res = res;
    end

    if (cmd_i.scan_step) begin
      idx_d = idx_q + SW'(1);
      if (hit) begin
        hit_res.ok            = 1'b1;
        hit_res.slot_out      = 4'(idx_q);
        hit_res.slot_present  = 1'b1;
        hit_res.slot_status   = slt_pkg::StError;
        hit_res.frame_total   = r_frame;
        hit_res.byte_total    = r_byte;
        hit_res.current_valid = sel_v_q;
        hit_res.current_slot  = sel_v_q ? 4'(sel_q) : 4'b0;
        hit_res.stream_count  = 5'(cnt_q);
        st_d[idx_q] = slt_pkg::StError;
        if (pend_v_q) begin
          push      = 1'b1;
          push_res  = pend_q;
          push_last = 1'b0;
        end
        pend_v_d = 1'b1;
        pend_d   = hit_res;
      end
    end

    if (cmd_i.fin) begin
      push     = 1'b1;
      pend_v_d = 1'b0;
      if (pend_v_q) begin
        push_res = pend_q;
      end else begin
        push_res.current_valid = sel_v_q;
        push_res.current_slot  = sel_v_q ? 4'(sel_q) : 4'b0;
        push_res.stream_count  = 5'(cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= slt_pkg::MaxStreamsRst;
      tmo_q    <= slt_pkg::TimeoutRst;
      pres_q   <= '0;
      st_q     <= '0;
      sel_v_q  <= 1'b0;
      sel_q    <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == slt_pkg::CfgMaxStreams) begin
          max_q <= cfg_data_i[4:0];
        end else if (cfg_idx_i == slt_pkg::CfgTimeout) begin
          tmo_q <= cfg_data_i;
        end
      end
      pres_q   <= pres_d;
      st_q     <= st_d;
      sel_v_q  <= sel_v_d;
      sel_q    <= sel_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= push | (out_v_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_kind_i;
      slot_q <= in_data_i[3:0];
      dsz_q  <= in_data_i[27:4];
      now_q  <= in_data_i[75:28];
    end
    pend_q <= pend_d;
    if (push) begin
      out_q      <= push_res;
      out_last_q <= push_last;
    end
  end

  assign stat_o.is_check  = (in_kind_i == slt_pkg::KIND_CHECK);
  assign stat_o.out_free  = !out_v_q || out_ready_i;
  assign stat_o.need_push = hit && pend_v_q;
  assign stat_o.scan_last = (idx_q == SW'(MaxSlots - 1));

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hw/rtl/channel_slot_table_with_timeout.sv =====
// Stream slot table with idle timeout: top level.
// Every command but check reads its entry RAM word on acceptance and executes in the EXEC
// state once the result register is free. Check scans all MaxSlots entries, each through
// the SCAN_RD and SCAN_TEST states via the entry RAM read port, then ends in the FIN state;
// results can stall it. One command in flight: a new one is accepted only when idle.
// Reset: slots absent, no selection, max_streams 16, timeout 10000 ms.
module channel_slot_table_with_timeout #(
  parameter int unsigned MaxSlots = slt_pkg::MaxSlotsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // slot, data_size, now_ms
  input  logic [3:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // ok, slot_out, slot_present, slot_status,
                                      // frame_total, byte_total, current_valid,
                                      // current_slot, stream_count
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);

  slt_pkg::cmd_t  cmd;
  slt_pkg::stat_t stat;
  slt_pkg::res_t  res;

  slt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  slt_dp #(
    .MaxSlots(MaxSlots)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, res};

endmodule

// ===== bench/tb.sv =====
// Testbench for the stream slot table: random and directed commands checked against a predictor.
module tb;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot_out;
    logic        present;
    logic [1:0]  status;
    logic [31:0] frames;
    logic [47:0] bytes;
    logic        cur_valid;
    logic [3:0]  cur_slot;
    logic [4:0]  count;
    logic        last;
  } slot_report_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic [23:0] size;
    logic [47:0] now;
  } cmd_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;
  logic [3:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [30:0]  cfg_data_i;

  channel_slot_table_with_timeout dut (.*);

  always #5 clk_i = ~clk_i;

  cmd_word_t    pending_cmds[$];
  slot_report_t expected_reports[$];
  cmd_word_t    cmd_on_bus;
  int           fail_count = 0;
  int           cycles = 0;
  bit           no_idle = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;
  logic [47:0]  clock_ms = 48'd0;

  // table copy
  logic [4:0]   tbl_max_streams;
  logic [30:0]  tbl_timeout;
  logic         tbl_present[16];
  logic [1:0]   tbl_status[16];
  logic [47:0]  tbl_seen[16];
  logic [31:0]  tbl_frames[16];
  logic [47:0]  tbl_bytes[16];
  logic         tbl_sel_valid;
  logic [3:0]   tbl_sel_slot;

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  function automatic int present_count();
    int n;
    n = 0;
    for (int i = 0; i < 16; i++) if (tbl_present[i]) n++;
    return n;
  endfunction

  function automatic slot_report_t describe(logic ok, int s);
    slot_report_t r;
    r = '0;
    r.ok = ok;
    if (s >= 0) begin
      r.slot_out = s[3:0];
      if (tbl_present[s]) begin
        r.present = 1'b1;
        r.status  = tbl_status[s];
        r.frames  = tbl_frames[s];
        r.bytes   = tbl_bytes[s];
      end
    end
    r.cur_valid = tbl_sel_valid;
    r.cur_slot  = tbl_sel_valid ? tbl_sel_slot : 4'd0;
    r.count     = 5'(present_count());
    return r;
  endfunction

  task automatic predict_reports(cmd_word_t c);
    slot_report_t out[$];
    int lim, s, got;
    logic present, valid, ok;
    logic [48:0] sum;
    lim = (tbl_max_streams > 16) ? 16 : tbl_max_streams;
    s = c.slot;
    present = tbl_present[s];
    valid = present && (s < lim);
    case (c.kind)
      slt_pkg::KIND_REGISTER: begin
        got = -1;
        if (present_count() < lim)
          for (int i = 0; i < lim; i++)
            if (!tbl_present[i] && got < 0) got = i;
        if (got >= 0) begin
          tbl_present[got] = 1'b1;
          tbl_status[got]  = slt_pkg::StRegistering;
          tbl_seen[got]    = c.now;
          tbl_frames[got]  = '0;
          tbl_bytes[got]   = '0;
        end
        out.push_back(describe(got >= 0, got));
      end
      slt_pkg::KIND_UNREGISTER: begin
        if (valid) begin
          if (tbl_sel_valid && tbl_sel_slot == s) begin
            tbl_sel_valid = 1'b0;
            tbl_sel_slot  = '0;
          end
          tbl_present[s] = 1'b0;
          tbl_status[s]  = slt_pkg::StRegistering;
        end
        out.push_back(describe(valid, s));
      end
      slt_pkg::KIND_ACTIVATE: begin
        if (valid) begin
          tbl_status[s] = slt_pkg::StActive;
          tbl_seen[s]   = c.now;
        end
        out.push_back(describe(valid, s));
      end
      slt_pkg::KIND_DEACTIVATE: begin
        if (valid) begin
          tbl_status[s] = slt_pkg::StInactive;
          if (tbl_sel_valid && tbl_sel_slot == s) begin
            tbl_sel_valid = 1'b0;
            tbl_sel_slot  = '0;
          end
        end
        out.push_back(describe(valid, s));
      end
      slt_pkg::KIND_SWITCH: begin
        ok = valid && tbl_status[s] == slt_pkg::StActive;
        if (ok) begin
          tbl_sel_valid = 1'b1;
          tbl_sel_slot  = s[3:0];
        end
        out.push_back(describe(ok, s));
      end
      slt_pkg::KIND_UPDATE: begin
        if (present) begin
          tbl_seen[s] = c.now;
          if (tbl_frames[s] != 32'hFFFF_FFFF) tbl_frames[s]++;
          sum = {1'b0, tbl_bytes[s]} + {25'd0, c.size};
          tbl_bytes[s] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        end
        out.push_back(describe(present, s));
      end
      slt_pkg::KIND_CHECK: begin
        for (int i = 0; i < 16; i++)
          if (tbl_present[i] && tbl_status[i] == slt_pkg::StActive && c.now > tbl_seen[i] &&
              c.now - tbl_seen[i] > {17'd0, tbl_timeout}) begin
            tbl_status[i] = slt_pkg::StError;
            out.push_back(describe(1'b1, i));
          end
        if (out.size() == 0) out.push_back(describe(1'b0, -1));
      end
      slt_pkg::KIND_QUERY: out.push_back(describe(present, s));
      slt_pkg::KIND_CLEAR: begin
        for (int i = 0; i < 16; i++) begin
          tbl_present[i] = 1'b0;
          tbl_status[i]  = slt_pkg::StRegistering;
        end
        tbl_sel_valid = 1'b0;
        tbl_sel_slot  = '0;
        out.push_back(describe(1'b1, -1));
      end
      default: out.push_back(describe(1'b0, -1));
    endcase
    out[out.size() - 1].last = 1'b1;
    foreach (out[i]) expected_reports.push_back(out[i]);
  endtask

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) predict_reports(cmd_on_bus);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0 && rst_ni) begin
        cmd_on_bus    <= pending_cmds[0];
        s_axis_tuser  <= pending_cmds[0].kind;
        s_axis_tdata  <= {4'd0, pending_cmds[0].now, pending_cmds[0].size,
                          pending_cmds[0].slot};
        s_axis_tvalid <= 1'b1;
        send_gap      <= pick_gap();
        void'(pending_cmds.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    slot_report_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[5], m_axis_tdata[7:6],
             m_axis_tdata[39:8], m_axis_tdata[87:40], m_axis_tdata[88],
             m_axis_tdata[92:89], m_axis_tdata[97:93], m_axis_tlast};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
          fail_count++;
        end
      end
    end
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_cmd(logic [3:0] kind, logic [3:0] slot, logic [23:0] size,
                         logic [47:0] now);
    cmd_word_t c;
    c.kind = kind;
    c.slot = slot;
    c.size = size;
    c.now  = now;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_reports.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == slt_pkg::CfgMaxStreams) tbl_max_streams = value[4:0];
    else tbl_timeout = value;
  endtask

  task automatic configure(logic [4:0] max_streams, logic [30:0] timeout);
    write_reg(slt_pkg::CfgMaxStreams, {26'd0, max_streams});
    write_reg(slt_pkg::CfgTimeout, timeout);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_random(int n);
    int r, lim;
    logic [3:0] kind, slot;
    logic [23:0] size;
    lim = (tbl_max_streams > 16) ? 16 : tbl_max_streams;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) kind = slt_pkg::KIND_REGISTER;
      else if (r < 28) kind = slt_pkg::KIND_UNREGISTER;
      else if (r < 43) kind = slt_pkg::KIND_ACTIVATE;
      else if (r < 50) kind = slt_pkg::KIND_DEACTIVATE;
      else if (r < 58) kind = slt_pkg::KIND_SWITCH;
      else if (r < 78) kind = slt_pkg::KIND_UPDATE;
      else if (r < 86) kind = slt_pkg::KIND_CHECK;
      else if (r < 93) kind = slt_pkg::KIND_QUERY;
      else if (r < 95) kind = slt_pkg::KIND_CLEAR;
      else kind = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 9) < 8 && lim > 0) slot = 4'($urandom_range(0, lim - 1));
      else slot = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 19);
      size = (r == 0) ? 24'hFF_FFFF : (r < 4) ? 24'($urandom) : 24'($urandom_range(0, 1500));
      r = $urandom_range(0, 19);
      if (r < 16) clock_ms = clock_ms + 48'($urandom_range(0, 60));
      else if (r < 18) clock_ms = clock_ms + 48'($urandom_range(0, 20000));
      else if (r < 19) clock_ms = clock_ms - 48'($urandom_range(0, 500));
      else clock_ms = 48'({$urandom, $urandom});
      add_cmd(kind, slot, size, clock_ms);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cmd_on_bus    = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = slt_pkg::CfgMaxStreams;
    cfg_data_i    = '0;
    tbl_max_streams = slt_pkg::MaxStreamsRst;
    tbl_timeout     = slt_pkg::TimeoutRst;
    for (int i = 0; i < 16; i++) begin
      tbl_present[i] = 1'b0;
      tbl_status[i]  = slt_pkg::StRegistering;
      tbl_seen[i]    = '0;
      tbl_frames[i]  = '0;
      tbl_bytes[i]   = '0;
    end
    tbl_sel_valid = 1'b0;
    tbl_sel_slot  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_cmd(slt_pkg::KIND_REGISTER, 4'd0, 24'd0, 48'd100);
    add_cmd(slt_pkg::KIND_REGISTER, 4'd0, 24'd0, 48'd100);
    add_cmd(slt_pkg::KIND_REGISTER, 4'd0, 24'd0, 48'hFFFF_FFFF_FFFF);
    add_cmd(slt_pkg::KIND_QUERY, 4'd0, 24'd0, 48'd100);
    add_cmd(slt_pkg::KIND_SWITCH, 4'd0, 24'd0, 48'd100);
    add_cmd(slt_pkg::KIND_ACTIVATE, 4'd0, 24'd0, 48'd200);
    add_cmd(slt_pkg::KIND_SWITCH, 4'd0, 24'd0, 48'd200);
    add_cmd(slt_pkg::KIND_UPDATE, 4'd0, 24'hFF_FFFF, 48'd300);
    add_cmd(slt_pkg::KIND_UPDATE, 4'd15, 24'd5, 48'd300);
    add_cmd(slt_pkg::KIND_ACTIVATE, 4'd1, 24'd0, 48'd300);
    add_cmd(slt_pkg::KIND_DEACTIVATE, 4'd1, 24'd0, 48'd300);
    add_cmd(slt_pkg::KIND_SWITCH, 4'd1, 24'd0, 48'd300);
    add_cmd(slt_pkg::KIND_ACTIVATE, 4'd1, 24'd0, 48'd300);
    add_cmd(slt_pkg::KIND_CHECK, 4'd0, 24'd0, 48'd10300);
    add_cmd(slt_pkg::KIND_CHECK, 4'd0, 24'd0, 48'd10302);
    add_cmd(slt_pkg::KIND_CHECK, 4'd0, 24'd0, 48'd50);
    add_cmd(slt_pkg::KIND_QUERY, 4'd1, 24'd0, 48'd0);
    add_cmd(slt_pkg::KIND_ACTIVATE, 4'd2, 24'd0, 48'd20000);
    add_cmd(slt_pkg::KIND_SWITCH, 4'd2, 24'd0, 48'd20000);
    add_cmd(slt_pkg::KIND_DEACTIVATE, 4'd2, 24'd0, 48'd20000);
    add_cmd(slt_pkg::KIND_UNREGISTER, 4'd0, 24'd0, 48'd20000);
    add_cmd(slt_pkg::KIND_UNREGISTER, 4'd9, 24'd0, 48'd20000);
    add_cmd(4'd15, 4'd15, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_cmd(slt_pkg::KIND_CLEAR, 4'd0, 24'd0, 48'd0);
    add_cmd(slt_pkg::KIND_QUERY, 4'd2, 24'd0, 48'd0);
    wait_drained();

    configure(5'd1, 31'd0);
    no_idle = 1'b1;
    add_random(30);
    wait_drained();

    configure(5'd16, 31'h7FFF_FFFF);
    no_idle = 1'b0;
    add_random(40);
    wait_drained();

    configure(5'd4, 31'd100);
    add_random(40);
    wait_drained();

    configure(5'd0, 31'd30);
    no_idle = 1'b1;
    add_random(15);
    wait_drained();

    configure(5'd31, 31'd50);
    no_idle = 1'b0;
    add_random(45);
    wait_drained();

    configure(5'd9, 31'd1000);
    add_random(15);
    wait_drained();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/slt_pkg.sv
hw/rtl/slt_ram.sv
hw/rtl/slt_ctrl.sv
hw/rtl/slt_dp.sv
hw/rtl/channel_slot_table_with_timeout.sv
bench/tb.sv
